[rtl/text_statistics_counter_top_defines.svh]
// Assertion macros shared by the text statistics RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef TEXT_STATISTICS_COUNTER_TOP_DEFINES_SVH
`define TEXT_STATISTICS_COUNTER_TOP_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define TSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define TSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tsc_pkg.sv]
// ----------------------------------------------------------------------------
// tsc_pkg
// Types and constants shared by the text statistics counter and its channels.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int CODE_W  = 21;
  localparam int FIELD_W = 32;
  localparam int THR_W   = 8;
  localparam int CFG_IDX_W = 4;

  localparam logic [CODE_W-1:0] CODE_SPACE   = 21'h20;
  localparam logic [CODE_W-1:0] CODE_NEWLINE = 21'h0A;
  localparam logic [CODE_W-1:0] ASCII_LAST   = 21'h7F;
  localparam logic [CODE_W-1:0] PRINT_LO     = 21'h20;
  localparam logic [CODE_W-1:0] PRINT_HI     = 21'h7E;
  localparam logic [CODE_W-1:0] DIGIT_LO     = 21'h30;
  localparam logic [CODE_W-1:0] DIGIT_HI     = 21'h39;
  localparam logic [CODE_W-1:0] UPPER_LO     = 21'h41;
  localparam logic [CODE_W-1:0] UPPER_HI     = 21'h5A;
  localparam logic [CODE_W-1:0] LOWER_LO     = 21'h61;
  localparam logic [CODE_W-1:0] LOWER_HI     = 21'h7A;

  localparam logic [THR_W-1:0] MIN_PARA_RESET = 8'd2;
  localparam logic [THR_W-1:0] MIN_WORD_RESET = 8'd4;

  // Register indexes on the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_PARA = 4'd0,
    CFG_MIN_WORD = 4'd1
  } cfg_idx_t;

  // Counter slots, in result field order
  typedef enum logic [3:0] {
    CNT_TOTAL = 4'd0,
    CNT_PRINT = 4'd1,
    CNT_DIGIT = 4'd2,
    CNT_ALPHA = 4'd3,
    CNT_PUNCT = 4'd4,
    CNT_SPACE = 4'd5,
    CNT_LINE  = 4'd6,
    CNT_WIDE  = 4'd7,
    CNT_WORD  = 4'd8,
    CNT_SMALL = 4'd9,
    CNT_WWORD = 4'd10,
    CNT_PARA  = 4'd11
  } cnt_idx_t;

  localparam int CNT_NUM = 12;

  typedef struct packed {
    logic [CODE_W-1:0] char_code;
    logic              last_char;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] total_chars;
    logic [FIELD_W-1:0] printable_chars;
    logic [FIELD_W-1:0] digit_chars;
    logic [FIELD_W-1:0] alpha_chars;
    logic [FIELD_W-1:0] punct_chars;
    logic [FIELD_W-1:0] space_chars;
    logic [FIELD_W-1:0] line_breaks;
    logic [FIELD_W-1:0] wide_chars;
    logic [FIELD_W-1:0] word_total;
    logic [FIELD_W-1:0] small_word_total;
    logic [FIELD_W-1:0] wide_word_total;
    logic [FIELD_W-1:0] paragraph_total;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [THR_W-1:0]     wr_data;
  } cfg_item_t;

endpackage

[rtl/tsc_stream_if.sv]
// ----------------------------------------------------------------------------
// tsc_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface tsc_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

[rtl/text_statistics_counter_top.sv]
// ----------------------------------------------------------------------------
// text_statistics_counter_top
// Streaming character, word and paragraph statistics over a code stream.
//
// Takes one character code per cycle, back to back, and keeps saturating
// counts of characters by ASCII class, of words (runs of non-space codes),
// small and wide words, and paragraphs (runs of non-newline codes). A
// character flagged last_char passes the input register and then loads the
// output register, which offers one result transfer with all twelve counts;
// the counts start over from zero for the next text. The character after a
// last one may follow in the very next cycle. The input stalls only while a
// finished result is held unread in the output register and another last
// character waits in the input register. The configuration channel is always
// ready; the user must write thresholds while the block is idle (unenforced).
// ----------------------------------------------------------------------------
`include "text_statistics_counter_top_defines.svh"

module text_statistics_counter_top #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  tsc_stream_if.sink    in_chan,
  tsc_stream_if.source  out_chan,
  tsc_stream_if.sink    cfg_chan
);

  import tsc_pkg::*;

  localparam logic [THR_W-1:0] LEN_MAX = '1;

  // Input register
  logic              s1_valid_r;
  logic [CODE_W-1:0] s1_code_r;
  logic              s1_last_r;
  logic              s1_adv;
  logic              in_fire;

  // Running state
  logic [COUNT_WIDTH-1:0] cnt_r   [CNT_NUM];
  logic [COUNT_WIDTH-1:0] cnt_nxt [CNT_NUM];
  logic [COUNT_WIDTH-1:0] cnt_fin [CNT_NUM];
  logic [FIELD_W-1:0]     cnt_cap [CNT_NUM];
  logic [CNT_NUM-1:0]     cnt_inc;
  logic [THR_W-1:0]       word_len_r, word_len_nxt;
  logic                   word_wide_r, word_wide_nxt;
  logic [THR_W-1:0]       para_len_r, para_len_nxt;

  // Thresholds
  logic [THR_W-1:0] min_para_r;
  logic [THR_W-1:0] min_word_r;

  // Output register
  logic      out_valid_r;
  out_item_t out_data_r;

  // Character classes
  logic is_digit, is_alpha, is_print, is_wide, is_space, is_nl;
  logic [THR_W-1:0] wl_post, pl_post, wclose_len, pclose_len;
  logic             wide_post, wclose_wide, word_close, para_close;

  // Advance the input register unless a last character would overwrite a
  // result that is still waiting
  assign s1_adv   = !(s1_valid_r && s1_last_r && out_valid_r && !out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
    if (in_fire) begin
      s1_code_r <= in_chan.data.char_code;
      s1_last_r <= in_chan.data.last_char;
    end
  end

  // Classify the held character
  always_comb begin
    is_digit = (s1_code_r >= DIGIT_LO) && (s1_code_r <= DIGIT_HI);
    is_alpha = ((s1_code_r >= UPPER_LO) && (s1_code_r <= UPPER_HI)) ||
               ((s1_code_r >= LOWER_LO) && (s1_code_r <= LOWER_HI));
    is_print = (s1_code_r >= PRINT_LO) && (s1_code_r <= PRINT_HI);
    is_wide  = s1_code_r > ASCII_LAST;
    is_space = s1_code_r == CODE_SPACE;
    is_nl    = s1_code_r == CODE_NEWLINE;
  end

  // Track the open word and paragraph; at most one of each closes per step
  always_comb begin
    wl_post     = is_space ? '0 : ((word_len_r == LEN_MAX) ? word_len_r : word_len_r + 1'b1);
    wide_post   = !is_space && (word_wide_r || is_wide);
    word_close  = is_space ? (word_len_r != '0) : s1_last_r;
    wclose_len  = is_space ? word_len_r : wl_post;
    wclose_wide = is_space ? word_wide_r : wide_post;

    pl_post     = is_nl ? '0 : ((para_len_r == LEN_MAX) ? para_len_r : para_len_r + 1'b1);
    para_close  = is_nl ? (para_len_r != '0) : s1_last_r;
    pclose_len  = is_nl ? para_len_r : pl_post;

    cnt_inc            = '0;
    cnt_inc[CNT_TOTAL] = 1'b1;
    cnt_inc[CNT_PRINT] = is_print;
    cnt_inc[CNT_DIGIT] = is_digit;
    cnt_inc[CNT_ALPHA] = is_alpha;
    cnt_inc[CNT_PUNCT] = is_print && !is_space && !is_digit && !is_alpha;
    cnt_inc[CNT_SPACE] = is_space;
    cnt_inc[CNT_LINE]  = is_nl;
    cnt_inc[CNT_WIDE]  = is_wide;
    cnt_inc[CNT_WORD]  = word_close;
    cnt_inc[CNT_SMALL] = word_close && (wclose_len < min_word_r);
    cnt_inc[CNT_WWORD] = word_close && wclose_wide;
    cnt_inc[CNT_PARA]  = para_close && (pclose_len >= min_para_r);

    // Clear everything after the last character
    word_len_nxt  = s1_last_r ? '0 : wl_post;
    word_wide_nxt = !s1_last_r && wide_post;
    para_len_nxt  = s1_last_r ? '0 : pl_post;
  end

  // Saturating counter updates and capping to the result field width
  for (genvar gi = 0; gi < CNT_NUM; gi++) begin : g_cnt
    assign cnt_fin[gi] = (&cnt_r[gi]) ? cnt_r[gi]
                                      : cnt_r[gi] + COUNT_WIDTH'(cnt_inc[gi]);
    assign cnt_nxt[gi] = s1_last_r ? '0 : cnt_fin[gi];
    if (COUNT_WIDTH > FIELD_W) begin : g_cap
      assign cnt_cap[gi] = (|cnt_fin[gi][COUNT_WIDTH-1:FIELD_W]) ? '1
                                                                 : cnt_fin[gi][FIELD_W-1:0];
    end else begin : g_ext
      assign cnt_cap[gi] = FIELD_W'(cnt_fin[gi]);
    end
  end

  // Hold running state; update on each advanced character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CNT_NUM; i++) begin
        cnt_r[i] <= '0;
      end
      word_len_r  <= '0;
      word_wide_r <= 1'b0;
      para_len_r  <= '0;
    end else if (s1_valid_r && s1_adv) begin
      for (int i = 0; i < CNT_NUM; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
      word_len_r  <= word_len_nxt;
      word_wide_r <= word_wide_nxt;
      para_len_r  <= para_len_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_para_r <= MIN_PARA_RESET;
      min_word_r <= MIN_WORD_RESET;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.data.reg_idx)
        CFG_MIN_PARA: min_para_r <= cfg_chan.data.wr_data;
        CFG_MIN_WORD: min_word_r <= cfg_chan.data.wr_data;
        default: begin
        end
      endcase
    end
  end

  // Result register: load on a last character, drop after its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && s1_last_r && s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_valid_r && s1_last_r && s1_adv) begin
      out_data_r.total_chars      <= cnt_cap[CNT_TOTAL];
      out_data_r.printable_chars  <= cnt_cap[CNT_PRINT];
      out_data_r.digit_chars      <= cnt_cap[CNT_DIGIT];
      out_data_r.alpha_chars      <= cnt_cap[CNT_ALPHA];
      out_data_r.punct_chars      <= cnt_cap[CNT_PUNCT];
      out_data_r.space_chars      <= cnt_cap[CNT_SPACE];
      out_data_r.line_breaks      <= cnt_cap[CNT_LINE];
      out_data_r.wide_chars       <= cnt_cap[CNT_WIDE];
      out_data_r.word_total       <= cnt_cap[CNT_WORD];
      out_data_r.small_word_total <= cnt_cap[CNT_SMALL];
      out_data_r.wide_word_total  <= cnt_cap[CNT_WWORD];
      out_data_r.paragraph_total  <= cnt_cap[CNT_PARA];
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // Checks
  `TSC_ASSERT_NEXT(a_last_clears, s1_valid_r && s1_last_r && s1_adv,
    out_valid_r && (cnt_r[CNT_TOTAL] == '0) && (word_len_r == '0) && (para_len_r == '0),
    "last character did not produce a result and clear state")
  `TSC_ASSERT_NOW(a_stall_cause, !in_chan.ready,
    s1_valid_r && s1_last_r && out_valid_r && !out_chan.ready,
    "input stalled without a held result blocking it")
  `TSC_ASSERT_NEXT(a_total_counts, s1_valid_r && s1_adv && !s1_last_r,
    cnt_r[CNT_TOTAL] != '0,
    "character did not advance the total count")
  `TSC_ASSERT_NOW(a_words_bounded, 1'b1,
    cnt_r[CNT_WORD] <= cnt_r[CNT_TOTAL],
    "word count exceeds character count")

endmodule
